/* design/pcd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_pkg: shared types and constants of the per-sender cooldown table
// Key layout, slot width, the token handed down the cell chain, the write-back
// bus, outcome codes, register addresses and the key canonicalization.
// ----------------------------------------------------------------------------
package pcd_pkg;

	// Slot numbers are carried at the width of the largest supported table.
	localparam int SLOT_W = 6;
	localparam int KEY_BYTES = 31;

	typedef logic [SLOT_W-1:0] slot_t;

	// First declared member sits in the high bits: word0 is the low 64 bits.
	typedef struct packed {
		logic [55:0] w3;
		logic [63:0] w2;
		logic [63:0] w1;
		logic [63:0] w0;
	} key_t;

	// Search status that travels from cell to cell.
	typedef struct packed {
		logic  valid;
		logic  found;
		slot_t hit_slot;
		logic  hit_ok;
		logic  avail_found;
		slot_t avail_slot;
	} token_t;

	// Broadcast write of a new sender into one entry.
	typedef struct packed {
		logic         en;
		slot_t        slot;
		key_t         key;
		logic [31:0]  now;
	} wr_bus_t;

	typedef enum logic [1:0] {
		OUT_EXPIRED = 2'd0,
		OUT_COOLING = 2'd1,
		OUT_NEW     = 2'd2,
		OUT_EVICT   = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESULT
	} state_t;

	// Register select bit of paddr (register i at byte address 4*i).
	localparam logic REG_COOLDOWN = 1'b0;
	localparam logic REG_STALE    = 1'b1;

	localparam logic [31:0] COOLDOWN_RESET = 32'd15000;
	localparam logic [31:0] STALE_RESET    = 32'd60000;

	// Zero every byte after the first zero byte of the key.
	function automatic key_t canon_key(input key_t k);
		logic [8*KEY_BYTES-1:0] f;
		logic                   ended;
		f = k;
		ended = 1'b0;
		for (int b = 0; b < KEY_BYTES; b++) begin
			if (ended) begin
				f[8*b +: 8] = 8'h00;
			end else if (f[8*b +: 8] == 8'h00) begin
				ended = 1'b1;
			end
		end
		return key_t'(f);
	endfunction

endpackage : pcd_pkg
`default_nettype wire

/* design/pcd_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_ifs: request and result channels of the per-sender cooldown table
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ----------------------------------------------------------------------------
interface pcd_req_if;
	logic        valid;
	logic        ready;
	logic [63:0] name_word0;
	logic [63:0] name_word1;
	logic [63:0] name_word2;
	logic [55:0] name_word3;
	logic [31:0] now_ms;

	modport source (output valid, name_word0, name_word1, name_word2, name_word3, now_ms,
		input ready);
	modport sink (input valid, name_word0, name_word1, name_word2, name_word3, now_ms,
		output ready);
endinterface : pcd_req_if

interface pcd_res_if;
	logic       valid;
	logic       ready;
	logic       allowed;
	logic [1:0] outcome;
	logic [3:0] slot;

	modport source (output valid, allowed, outcome, slot, input ready);
	modport sink (input valid, allowed, outcome, slot, output ready);
endinterface : pcd_res_if
`default_nettype wire

/* design/per_sender_cooldown_table_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// per_sender_cooldown_table_unit: per-sender cooldown rate limiter
// A chain of TABLE_ENTRIES cells, one entry each, scanned by a search token.
// ----------------------------------------------------------------------------
// A request transfer is registered into start_q, which injects the search token;
//   the token walks the cell registers one entry per cycle, and the result is
//   registered and presented in ST_RESULT once the token leaves the last cell.
// One request is in flight at a time; the next is taken as the result leaves.
// Reset (arst_n low) clears all entry valid bits and loads the register
//   defaults (cooldown 15000 ms, stale age 60000 ms); no clearing pass needed.
module per_sender_cooldown_table_unit #(
	parameter int TABLE_ENTRIES = 10
) (
	input  wire         clk,
	input  wire         arst_n,
	pcd_req_if.sink     req,
	pcd_res_if.source   res,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import pcd_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [31:0] cooldown_q;
	logic [31:0] stale_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_q <= COOLDOWN_RESET;
			stale_q    <= STALE_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_COOLDOWN: cooldown_q <= pwdata;
				REG_STALE:    stale_q    <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_COOLDOWN: prdata = cooldown_q;
			REG_STALE:    prdata = stale_q;
			default:      prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Request control
	// ------------------------------------------------------------------
	state_t      state_q;
	state_t      state_d;
	logic        req_xfer;
	logic        res_xfer;
	logic        start_q;
	key_t        key_q;
	logic [31:0] now_q;
	key_t        key_in;

	token_t      tok [TABLE_ENTRIES+1];
	token_t      tok_end;
	wr_bus_t     wr;

	logic        allowed_q;
	outcome_t    outcome_q;
	logic [3:0]  slot_q;

	assign req.ready = (state_q == ST_IDLE) || ((state_q == ST_RESULT) && res.ready);
	assign req_xfer  = req.valid && req.ready;
	assign res_xfer  = res.valid && res.ready;
	assign tok_end   = tok[TABLE_ENTRIES];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_xfer) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				// Token left the last cell: result and write-back are ready.
				if (tok_end.valid) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (req_xfer) state_d = ST_SCAN;
				else if (res_xfer) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= req_xfer;
		end
	end

	// Canonicalize the key once on transfer; hold key and time for the scan.
	assign key_in = canon_key(key_t'({req.name_word3, req.name_word2,
		req.name_word1, req.name_word0}));

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			key_q <= key_in;
			now_q <= req.now_ms;
		end
	end

	// ------------------------------------------------------------------
	// Cell chain: inject a fresh token, walk one entry per cycle
	// ------------------------------------------------------------------
	always_comb begin
		tok[0]       = '0;
		tok[0].valid = start_q;
	end

	for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
		pcd_cell #(
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key_q),
			.now      (now_q),
			.cooldown (cooldown_q),
			.stale    (stale_q),
			.tok_i    (tok[i]),
			.wr       (wr),
			.tok_o    (tok[i+1])
		);
	end

	// Unknown sender: write into the first free or stale entry, else entry 0.
	always_comb begin
		wr.en   = tok_end.valid && !tok_end.found;
		wr.slot = tok_end.avail_found ? tok_end.avail_slot : '0;
		wr.key  = key_q;
		wr.now  = now_q;
	end

	// ------------------------------------------------------------------
	// Result register
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (tok_end.valid) begin
			if (tok_end.found) begin
				allowed_q <= tok_end.hit_ok;
				outcome_q <= tok_end.hit_ok ? OUT_EXPIRED : OUT_COOLING;
				slot_q    <= tok_end.hit_slot[3:0];
			end else begin
				allowed_q <= 1'b1;
				outcome_q <= tok_end.avail_found ? OUT_NEW : OUT_EVICT;
				slot_q    <= wr.slot[3:0];
			end
		end
	end

	assign res.valid   = (state_q == ST_RESULT);
	assign res.allowed = allowed_q;
	assign res.outcome = outcome_q;
	assign res.slot    = slot_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	logic [TABLE_ENTRIES:0] tok_valids;

	always_comb begin
		for (int i = 0; i <= TABLE_ENTRIES; i++) begin
			tok_valids[i] = tok[i].valid;
		end
	end

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valids))
		else $error("more than one search token in the cell chain");

	a_end_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_end.valid |-> state_q == ST_SCAN)
		else $error("token reached chain end outside a scan");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		tok_end.valid |=> res.valid)
		else $error("result not presented after scan end");

	a_evict_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.outcome == OUT_EVICT) |-> res.slot == 4'd0)
		else $error("eviction reported for a slot other than zero");

endmodule : per_sender_cooldown_table_unit
`default_nettype wire

/* design/pcd_cell.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pcd_cell: one table entry of the cooldown chain
// Holds valid, key and last-allowed time; checks the passing token for a key
// hit and for a free or stale entry, and takes write-back writes.
// ----------------------------------------------------------------------------
module pcd_cell #(
	parameter int INDEX = 0
) (
	input  wire              clk,
	input  wire              arst_n,
	input  pcd_pkg::key_t    key,
	input  wire [31:0]       now,
	input  wire [31:0]       cooldown,
	input  wire [31:0]       stale,
	input  pcd_pkg::token_t  tok_i,
	input  pcd_pkg::wr_bus_t wr,
	output pcd_pkg::token_t  tok_o
);
	import pcd_pkg::*;

	logic        valid_q;
	key_t        key_q;
	logic [31:0] last_q;
	token_t      tok_q;

	logic [31:0] elapsed;
	logic        hit;
	logic        ok;
	logic        avail;
	logic        take_avail;
	logic        wr_here;
	token_t      tok_d;

	assign elapsed    = now - last_q;
	assign hit        = tok_i.valid && !tok_i.found && valid_q && (key_q == key);
	assign ok         = elapsed >= cooldown;
	assign avail      = !valid_q || ((now >= last_q) && (elapsed >= stale));
	assign take_avail = tok_i.valid && !tok_i.avail_found && avail;
	assign wr_here    = wr.en && (wr.slot == slot_t'(INDEX));

	always_comb begin
		tok_d = tok_i;
		if (hit) begin
			tok_d.found    = 1'b1;
			tok_d.hit_slot = slot_t'(INDEX);
			tok_d.hit_ok   = ok;
		end
		if (take_avail) begin
			tok_d.avail_found = 1'b1;
			tok_d.avail_slot  = slot_t'(INDEX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			tok_q <= tok_d;
			if (wr_here) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_here) begin
			key_q  <= wr.key;
			last_q <= wr.now;
		end else if (hit && ok) begin
			last_q <= now;
		end
	end

	assign tok_o = tok_q;

endmodule : pcd_cell
`default_nettype wire
